[rtl/assert_macros.svh]
// assertion helpers included by the rtl top level
// every check is sampled on clk and held off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in a cycle, consequent holds in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds in a cycle, consequent holds in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/tple_pkg.sv]
// shared types and constants for the timeline pwm led engine
// no dependencies; used by the interfaces, the ram wrapper user and the top level
`timescale 1ns / 1ps

package tple_pkg;

	localparam int TABLE_DEPTH = 128;
	localparam int TBL_AW      = $clog2(TABLE_DEPTH);

	localparam int NUM_LEDS = 8;
	localparam int LED_W    = 3;
	localparam int LVL_W    = 3;
	localparam int CL_W     = 7;
	localparam int POS_W    = 7;
	localparam int ADDR_W   = 7;
	localparam int WORD_W   = 8;
	localparam int KIND_W   = 2;

	// index before reduction: at most cycle_length + 7
	localparam int IDX_W    = 8;
	localparam int IDX_SPAN = 2 ** IDX_W;

	localparam logic [CL_W-1:0] CL_RESET = CL_W'(120);

	// timeline word layout
	localparam int WORD_NOP_BIT   = 7;
	localparam int WORD_FORCE_BIT = 3;
	localparam int WORD_LVL_LSB   = 4;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK  = 2'd0,
		KIND_SET   = 2'd1,
		KIND_WRITE = 2'd2
	} kind_t;

	typedef logic [TBL_AW-1:0] tbl_addr_t;
	typedef tbl_addr_t mod_lut_t [IDX_SPAN];

	// index reduction modulo the table depth, built at elaboration
	function automatic mod_lut_t build_mod_lut();
		mod_lut_t lut;
		for (int i = 0; i < IDX_SPAN; i++) begin
			lut[i] = tbl_addr_t'(i % TABLE_DEPTH);
		end
		return lut;
	endfunction

	localparam mod_lut_t MOD_LUT = build_mod_lut();

endpackage

[rtl/tple_ifs.sv]
// valid/ready channel interfaces: command channel and led latch channel
// depends on tple_pkg for the payload widths
`timescale 1ns / 1ps

interface tple_cmd_if import tple_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [KIND_W-1:0]      kind;
	logic [LED_W-1:0]       led_index;
	logic [LVL_W-1:0]       intensity;
	logic [ADDR_W-1:0]      table_address;
	logic [WORD_W-1:0]      table_word;

	modport source (output valid, kind, led_index, intensity, table_address, table_word,
		input ready);
	modport sink (input valid, kind, led_index, intensity, table_address, table_word,
		output ready);
endinterface

interface tple_led_if import tple_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LED_W-1:0] out_led;
	logic             out_level;

	modport source (output valid, out_led, out_level, input ready);
	modport sink (input valid, out_led, out_level, output ready);
endinterface

[rtl/tple_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module tple_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/timeline_pwm_led_engine.sv]
// top level of the eight-channel timeline pwm led engine
// depends on tple_pkg, tple_ifs (channel interfaces), tple_ram and assert_macros.svh
`timescale 1ns / 1ps

// One command transaction is taken per clock while cmd.ready is high; ready drops during a
// mirror reload and while a latch waits on the led channel. Intensity sets and table writes
// finish at the edge that takes them; a tick reads the timeline ram at that edge (registered
// read), decides its action in the following cycle and, if it drives a latch, presents
// out_led/out_level on the led channel from an output register. Ticks may follow each other
// every cycle while the led channel keeps up; the one-port timeline ram read sets that figure.
// The eight sync positions are mirrored in flip-flops: table writes update the mirror
// directly, and each cycle_length write starts a reload of the mirror from the ram, during
// which no command transaction is taken.
module timeline_pwm_led_engine import tple_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CL_W-1:0]  cfg_wdata,
	tple_cmd_if.sink         cmd,
	tple_led_if.source       led
);

	`include "assert_macros.svh"

	logic [CL_W-1:0]                       cl_q;
	logic [POS_W-1:0]                      pos_q;
	logic [NUM_LEDS-1:0][LVL_W-1:0]        brightness_q;
	logic [NUM_LEDS-1:0][LVL_W-1:0]        pending_level_q;
	logic [NUM_LEDS-1:0]                   pending_flag_q;
	logic [NUM_LEDS-1:0][WORD_W-1:0]       sync_q;

	logic                                  refill_active_q;
	logic [LED_W-1:0]                      refill_idx_q;
	logic                                  cap_valid_q;
	logic [LED_W-1:0]                      cap_idx_q;

	logic                                  valid_s1;
	logic                                  out_valid_q;
	logic [LED_W-1:0]                      out_led_q;
	logic                                  out_level_q;

	logic                                  cmd_acc;
	logic                                  tick_acc;
	logic                                  set_acc;
	logic                                  wr_acc;
	logic [NUM_LEDS-1:0]                   sync_hit;
	logic [NUM_LEDS-1:0]                   wr_sync_hit;
	tbl_addr_t                             wr_addr;
	tbl_addr_t                             rd_addr;
	logic                                  rd_en;
	logic [WORD_W-1:0]                     rd_word;
	logic [POS_W-1:0]                      pos_inc;

	logic [LED_W-1:0]                      act_led;
	logic [LVL_W-1:0]                      act_lvl;
	logic [LVL_W-1:0]                      act_bright;
	logic                                  act_force;
	logic                                  hit_s1;
	logic                                  level_s1;
	logic                                  out_free;
	logic                                  s1_free;

	// ---------------------------------------------------------------- handshake
	assign out_free = !out_valid_q || led.ready;
	assign s1_free  = !valid_s1 || !hit_s1 || out_free;

	assign cmd.ready = !refill_active_q && !cap_valid_q && s1_free;
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign tick_acc  = cmd_acc && (cmd.kind == KIND_TICK);
	assign set_acc   = cmd_acc && (cmd.kind == KIND_SET);
	assign wr_acc    = cmd_acc && (cmd.kind == KIND_WRITE);

	// ---------------------------------------------------------------- timeline ram
	assign wr_addr = MOD_LUT[IDX_W'(cmd.table_address)];
	assign rd_en   = tick_acc || refill_active_q;

	always_comb begin
		if (refill_active_q) begin
			rd_addr = MOD_LUT[IDX_W'(cl_q) + IDX_W'(refill_idx_q)];
		end else begin
			rd_addr = MOD_LUT[IDX_W'(pos_q)];
		end
	end

	tple_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_DEPTH)
	) u_timeline (
		.clk   (clk),
		.we    (wr_acc),
		.waddr (wr_addr),
		.wdata (cmd.table_word),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_word)
	);

	// ---------------------------------------------------------------- sync matching
	always_comb begin
		for (int n = 0; n < NUM_LEDS; n++) begin
			sync_hit[n]    = pending_flag_q[n] && (sync_q[n] == WORD_W'(pos_q));
			wr_sync_hit[n] = (MOD_LUT[IDX_W'(cl_q) + IDX_W'(n)] == wr_addr);
		end
	end

	assign pos_inc = pos_q + POS_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cl_q           <= CL_RESET;
			pos_q          <= '0;
			brightness_q   <= '0;
			pending_flag_q <= '0;
		end else begin
			if (cfg_we) begin
				cl_q <= cfg_wdata;
			end
			if (tick_acc) begin
				pos_q <= (pos_inc == POS_W'(cl_q)) ? '0 : pos_inc;
				for (int n = 0; n < NUM_LEDS; n++) begin
					if (sync_hit[n]) begin
						brightness_q[n]   <= pending_level_q[n];
						pending_flag_q[n] <= 1'b0;
					end
				end
			end
			if (set_acc) begin
				pending_flag_q[cmd.led_index] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (set_acc) begin
			pending_level_q[cmd.led_index] <= cmd.intensity;
		end
		// write-through keeps the sync mirror in step with the ram
		if (wr_acc) begin
			for (int n = 0; n < NUM_LEDS; n++) begin
				if (wr_sync_hit[n]) begin
					sync_q[n] <= cmd.table_word;
				end
			end
		end
		if (cap_valid_q) begin
			sync_q[cap_idx_q] <= rd_word;
		end
	end

	// ---------------------------------------------------------------- sync mirror reload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refill_active_q <= 1'b0;
			refill_idx_q    <= '0;
			cap_valid_q     <= 1'b0;
			cap_idx_q       <= '0;
		end else begin
			if (cfg_we) begin
				refill_active_q <= 1'b1;
				refill_idx_q    <= '0;
				cap_valid_q     <= 1'b0;
			end else begin
				cap_valid_q <= refill_active_q;
				cap_idx_q   <= refill_idx_q;
				if (refill_active_q) begin
					refill_idx_q <= refill_idx_q + LED_W'(1);
					if (refill_idx_q == LED_W'(NUM_LEDS - 1)) begin
						refill_active_q <= 1'b0;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- action stage
	assign act_led    = rd_word[LED_W-1:0];
	assign act_lvl    = rd_word[WORD_LVL_LSB +: LVL_W];
	assign act_force  = rd_word[WORD_FORCE_BIT];
	assign act_bright = brightness_q[act_led];

	assign hit_s1   = valid_s1 && !rd_word[WORD_NOP_BIT] &&
		(act_force || (act_lvl == act_bright));
	assign level_s1 = act_force && (act_bright != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= tick_acc;
			end
			if (hit_s1 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (led.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_s1 && out_free) begin
			out_led_q   <= act_led;
			out_level_q <= level_s1;
		end
	end

	assign led.valid     = out_valid_q;
	assign led.out_led   = out_led_q;
	assign led.out_level = out_level_q;

	// ---------------------------------------------------------------- checks
	`ASSERT_NEXT(a_out_needs_tick, !valid_s1 && !out_valid_q, !out_valid_q,
		"led transaction appeared without a tick in flight")
	`ASSERT_NEXT(a_flag_set_by_cmd, !set_acc,
		(pending_flag_q & ~$past(pending_flag_q)) == '0,
		"pending flag raised without an intensity command")
	`ASSERT_NEXT(a_bright_on_tick, !tick_acc, $stable(brightness_q),
		"brightness changed outside a tick")
	`ASSERT_SAME(a_refill_quiet, refill_active_q || cap_valid_q, !cmd_acc && !valid_s1,
		"command traffic during sync mirror reload")

endmodule
